/* design/swfadp_pkg.sv */
// Shared types, constants and lookup functions of the SWF ADPCM sample decoder.
// Used by every module of the decoder; has no dependencies of its own.
package swfadp_pkg;

	localparam int CHANNELS_DEF = 2;

	localparam int STEP_COUNT = 89;
	localparam logic [6:0] IDX_MAX = 7'(STEP_COUNT - 1);

	localparam logic [2:0] CODE_WIDTH_RESET = 3'd4;
	localparam logic [2:0] CODE_WIDTH_MIN = 3'd2;
	localparam logic [2:0] CODE_WIDTH_MAX = 3'd5;

	localparam logic signed [17:0] SUM_MIN = -18'sd32768;
	localparam logic signed [17:0] SUM_MAX = 18'sd32767;

	// Configuration register indexes.
	localparam logic [0:0] CFG_CODE_WIDTH = 1'b0;
	localparam logic [0:0] CFG_STEREO = 1'b1;

	// Request types.
	localparam logic REQ_HEADER = 1'b0;
	localparam logic REQ_CODE = 1'b1;

	typedef struct packed {
		logic signed [15:0] pred;
		logic [6:0] idx;
	} chan_state_t;

	typedef struct packed {
		logic req_type;
		logic [4:0] code;
		logic signed [15:0] initial_sample;
		logic [5:0] initial_index;
	} item_t;

	function automatic logic [14:0] step_size(input logic [6:0] idx);
		logic [14:0] s;
		begin
			case (idx)
				7'd0: s = 15'd7;
				7'd1: s = 15'd8;
				7'd2: s = 15'd9;
				7'd3: s = 15'd10;
				7'd4: s = 15'd11;
				7'd5: s = 15'd12;
				7'd6: s = 15'd13;
				7'd7: s = 15'd14;
				7'd8: s = 15'd16;
				7'd9: s = 15'd17;
				7'd10: s = 15'd19;
				7'd11: s = 15'd21;
				7'd12: s = 15'd23;
				7'd13: s = 15'd25;
				7'd14: s = 15'd28;
				7'd15: s = 15'd31;
				7'd16: s = 15'd34;
				7'd17: s = 15'd37;
				7'd18: s = 15'd41;
				7'd19: s = 15'd45;
				7'd20: s = 15'd50;
				7'd21: s = 15'd55;
				7'd22: s = 15'd60;
				7'd23: s = 15'd66;
				7'd24: s = 15'd73;
				7'd25: s = 15'd80;
				7'd26: s = 15'd88;
				7'd27: s = 15'd97;
				7'd28: s = 15'd107;
				7'd29: s = 15'd118;
				7'd30: s = 15'd130;
				7'd31: s = 15'd143;
				7'd32: s = 15'd157;
				7'd33: s = 15'd173;
				7'd34: s = 15'd190;
				7'd35: s = 15'd209;
				7'd36: s = 15'd230;
				7'd37: s = 15'd253;
				7'd38: s = 15'd279;
				7'd39: s = 15'd307;
				7'd40: s = 15'd337;
				7'd41: s = 15'd371;
				7'd42: s = 15'd408;
				7'd43: s = 15'd449;
				7'd44: s = 15'd494;
				7'd45: s = 15'd544;
				7'd46: s = 15'd598;
				7'd47: s = 15'd658;
				7'd48: s = 15'd724;
				7'd49: s = 15'd796;
				7'd50: s = 15'd876;
				7'd51: s = 15'd963;
				7'd52: s = 15'd1060;
				7'd53: s = 15'd1166;
				7'd54: s = 15'd1282;
				7'd55: s = 15'd1411;
				7'd56: s = 15'd1552;
				7'd57: s = 15'd1707;
				7'd58: s = 15'd1878;
				7'd59: s = 15'd2066;
				7'd60: s = 15'd2272;
				7'd61: s = 15'd2499;
				7'd62: s = 15'd2749;
				7'd63: s = 15'd3024;
				7'd64: s = 15'd3327;
				7'd65: s = 15'd3660;
				7'd66: s = 15'd4026;
				7'd67: s = 15'd4428;
				7'd68: s = 15'd4871;
				7'd69: s = 15'd5358;
				7'd70: s = 15'd5894;
				7'd71: s = 15'd6484;
				7'd72: s = 15'd7132;
				7'd73: s = 15'd7845;
				7'd74: s = 15'd8630;
				7'd75: s = 15'd9493;
				7'd76: s = 15'd10442;
				7'd77: s = 15'd11487;
				7'd78: s = 15'd12635;
				7'd79: s = 15'd13899;
				7'd80: s = 15'd15289;
				7'd81: s = 15'd16818;
				7'd82: s = 15'd18500;
				7'd83: s = 15'd20350;
				7'd84: s = 15'd22385;
				7'd85: s = 15'd24623;
				7'd86: s = 15'd27086;
				7'd87: s = 15'd29794;
				default: s = 15'd32767;
			endcase
			return s;
		end
	endfunction

	// Step index adjustment by effective code width (2..5) and magnitude.
	function automatic logic signed [5:0] index_adjust(input logic [2:0] bits,
			input logic [3:0] mag);
		logic signed [5:0] a;
		begin
			a = 6'sd0;
			case (bits)
				3'd2: begin
					case (mag)
						4'd0: a = -6'sd1;
						4'd1: a = 6'sd2;
						default: a = 6'sd0;
					endcase
				end
				3'd3: begin
					case (mag)
						4'd0, 4'd1: a = -6'sd1;
						4'd2: a = 6'sd2;
						4'd3: a = 6'sd4;
						default: a = 6'sd0;
					endcase
				end
				3'd4: begin
					case (mag)
						4'd0, 4'd1, 4'd2, 4'd3: a = -6'sd1;
						4'd4: a = 6'sd2;
						4'd5: a = 6'sd4;
						4'd6: a = 6'sd6;
						4'd7: a = 6'sd8;
						default: a = 6'sd0;
					endcase
				end
				default: begin
					case (mag)
						4'd8: a = 6'sd1;
						4'd9: a = 6'sd2;
						4'd10: a = 6'sd4;
						4'd11: a = 6'sd6;
						4'd12: a = 6'sd8;
						4'd13: a = 6'sd10;
						4'd14: a = 6'sd13;
						4'd15: a = 6'sd16;
						default: a = -6'sd1;
					endcase
				end
			endcase
			return a;
		end
	endfunction

endpackage

/* design/swf_adpcm_sample_decoder_unit.sv */
// SWF-style IMA ADPCM sample decoder (2 to 5 bit codes, mono or stereo). It takes one
// item per clock unless the output stalls, a block header or one code for one channel,
// and returns one 16-bit sample per item through the input and output registers. The
// rate is one item per cycle while the output is not stalled because each item's step
// table lookup, 15x5 multiply, add, saturation and index update fit between the input
// register and the output register, and the channel state written as an item leaves the
// input register is already visible to the next item. Configuration is never held off.
module swf_adpcm_sample_decoder_unit #(
	parameter int CHANNELS = swfadp_pkg::CHANNELS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic req_type,
	input  logic channel,
	input  logic [4:0] code,
	input  logic signed [15:0] initial_sample,
	input  logic [5:0] initial_index,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [15:0] sample,
	output logic out_channel,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic [2:0] cfg_data
);
	import swfadp_pkg::*;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [2:0] code_width_q;
	logic stereo_q;

	logic valid_s1;
	item_t item_s1;
	logic ch_s1;
	logic valid_s2;
	logic signed [15:0] sample_s2;
	logic ch_s2;

	logic accept;
	logic advance_s1;
	logic ch_in;
	item_t item_in;
	chan_state_t cur_state;
	chan_state_t nxt_state;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_width_q <= CODE_WIDTH_RESET;
			stereo_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CODE_WIDTH: code_width_q <= cfg_data;
				CFG_STEREO: stereo_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The input register moves on whenever the output register is empty or drained.
	assign advance_s1 = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance_s1;
	assign accept = in_valid && !in_stall;

	assign ch_in = (CHANNELS > 1) ? (stereo_q & channel) : 1'b0;
	assign item_in = '{req_type: req_type, code: code, initial_sample: initial_sample,
			initial_index: initial_index};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
			ch_s1 <= ch_in;
		end
	end

	swfadp_chan_state #(
		.CHANNELS(CHANNELS)
	) u_state (
		.clk(clk),
		.arst_n(arst_n),
		.ch(CH_W'(ch_s1)),
		.wr_en(advance_s1),
		.wr_data(nxt_state),
		.rd_data(cur_state)
	);

	swfadp_datapath u_dp (
		.item(item_s1),
		.code_width(code_width_q),
		.cur(cur_state),
		.nxt(nxt_state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			sample_s2 <= nxt_state.pred;
			ch_s2 <= ch_s1;
		end
	end

	assign out_valid = valid_s2;
	assign sample = sample_s2;
	assign out_channel = ch_s2;

endmodule

/* design/swfadp_chan_state.sv */
// Per-channel decoder state: predicted sample and step index for each channel.
// Depends on swfadp_pkg for the channel state type.
module swfadp_chan_state #(
	parameter int CHANNELS = swfadp_pkg::CHANNELS_DEF,
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [CH_W-1:0] ch,
	input  logic wr_en,
	input  swfadp_pkg::chan_state_t wr_data,
	output swfadp_pkg::chan_state_t rd_data
);
	import swfadp_pkg::*;

	chan_state_t st_q [CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				st_q[i] <= '0;
			end
		end else if (wr_en) begin
			st_q[ch] <= wr_data;
		end
	end

	assign rd_data = st_q[ch];

endmodule

/* design/swfadp_datapath.sv */
// Combinational decode of one item: header load or ADPCM code update.
// Depends on swfadp_pkg for the step table, index adjustment and types.
module swfadp_datapath (
	input  swfadp_pkg::item_t item,
	input  logic [2:0] code_width,
	input  swfadp_pkg::chan_state_t cur,
	output swfadp_pkg::chan_state_t nxt
);
	import swfadp_pkg::*;

	logic [2:0] eff_bits;
	logic [2:0] shamt;
	logic sign;
	logic [3:0] mag;
	logic [6:0] idx_c;
	logic [14:0] step;
	logic [19:0] prod;
	logic [19:0] delta;
	logic signed [17:0] p18;
	logic signed [17:0] d18;
	logic signed [17:0] sum;
	logic signed [5:0] adj;
	logic signed [8:0] ni;

	always_comb begin
		if (code_width < CODE_WIDTH_MIN) begin
			eff_bits = CODE_WIDTH_MIN;
		end else if (code_width > CODE_WIDTH_MAX) begin
			eff_bits = CODE_WIDTH_MAX;
		end else begin
			eff_bits = code_width;
		end
		shamt = eff_bits - 3'd1;

		// The sign is the top bit of the code width; bits above it are ignored.
		unique case (eff_bits)
			3'd2: begin
				sign = item.code[1];
				mag = {3'b000, item.code[0]};
			end
			3'd3: begin
				sign = item.code[2];
				mag = {2'b00, item.code[1:0]};
			end
			3'd4: begin
				sign = item.code[3];
				mag = {1'b0, item.code[2:0]};
			end
			default: begin
				sign = item.code[4];
				mag = item.code[3:0];
			end
		endcase

		idx_c = (cur.idx > IDX_MAX) ? IDX_MAX : cur.idx;
		step = step_size(idx_c);
		prod = {5'b0, step} * {15'b0, mag, 1'b1};
		delta = prod >> shamt;

		p18 = {{2{cur.pred[15]}}, cur.pred};
		d18 = {2'b00, delta[15:0]};
		sum = sign ? (p18 - d18) : (p18 + d18);

		adj = index_adjust(eff_bits, mag);
		ni = $signed({2'b00, idx_c}) + {{3{adj[5]}}, adj};

		if (item.req_type == REQ_HEADER) begin
			nxt.pred = item.initial_sample;
			nxt.idx = {1'b0, item.initial_index};
		end else begin
			if (sum < SUM_MIN) begin
				nxt.pred = SUM_MIN[15:0];
			end else if (sum > SUM_MAX) begin
				nxt.pred = SUM_MAX[15:0];
			end else begin
				nxt.pred = sum[15:0];
			end
			if (ni < 9'sd0) begin
				nxt.idx = 7'd0;
			end else if (ni > $signed({2'b00, IDX_MAX})) begin
				nxt.idx = IDX_MAX;
			end else begin
				nxt.idx = ni[6:0];
			end
		end
	end

endmodule

/* design/swfadp_checker.sv */
// Port-level checks for the SWF ADPCM sample decoder, bound to its top level.
// Depends only on the top level's ports.
module swfadp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [15:0] sample,
	input logic out_channel,
	input logic cfg_ready
);

	// A stalled result transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample) && $stable(out_channel))
		else $error("stalled result changed");

	// The input side only stalls when a result is waiting at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	// A result appearing at an empty output comes from an item taken through the input register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a matching input transaction");

	// Configuration writes are never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind swf_adpcm_sample_decoder_unit swfadp_checker u_chk (.*);
